FILE: sv/vector_mean_variance_top_assert.svh
// Assertion macros for the port checker module of the mean and variance block.
`ifndef VECTOR_MEAN_VARIANCE_TOP_ASSERT_SVH
`define VECTOR_MEAN_VARIANCE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define VMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define VMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vmv_pkg.sv
// Package with the sizes, types and sequencer states of the mean and variance block.
`default_nettype none

package vmv_pkg;

    localparam int MAX_VECTORS  = 1024;
    localparam int DIMENSIONS   = 7;
    localparam int SAMPLE_WIDTH = 24;

    localparam int ADDR_W = $clog2(MAX_VECTORS);
    localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
    localparam int DIM_W  = 3;
    localparam int SUM_W  = SAMPLE_WIDTH + ADDR_W;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int ACC_W  = SQ_W + ADDR_W;
    localparam int VAR_W  = 48;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t [DIMENSIONS-1:0]       row_t;
    typedef logic [DIM_W-1:0]               dim_t;
    typedef logic [VAR_W-1:0]               var_t;
    typedef logic [CNT_W-1:0]               count_t;
    typedef logic [ACC_W-1:0]               wide_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_MEAN,
        ST_PASS,
        ST_VDIV,
        ST_EMIT
    } vmv_state_t;

endpackage

`default_nettype wire

FILE: sv/vmv_div.sv
// Bit-serial restoring divider shared by the mean and variance computations.
`default_nettype none

module vmv_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire vmv_pkg::wide_t  dividend,
    input  wire vmv_pkg::count_t divisor,
    output logic                 done,
    output vmv_pkg::wide_t       quotient
);
    import vmv_pkg::*;

    localparam int STEP_W = $clog2(ACC_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    wide_t             quo_reg;
    logic [CNT_W:0]    rem_shift;
    logic              fits;
    logic [CNT_W:0]    rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ACC_W-1]};
        fits      = rem_shift >= {1'b0, divisor};
        rem_next  = fits ? rem_shift - {1'b0, divisor} : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[CNT_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: sv/vector_mean_variance_top.sv
// Top level of the per-component mean and population variance block.
//
// The block takes one seven-component vector per cycle into a 1024-row
// vector memory while sample_stall is low, keeping running sums per
// component. The request marked last_vector closes the set; from then on
// sample_stall stays high while one bit-serial divider and one squaring
// pipeline work through the components one at a time. Each component takes
// 58 divider steps for the mean, one memory row per cycle for the squared
// distances, and 58 divider steps for the variance. Results leave through an
// output register, so the next set may start loading while the final result
// still waits. The vector memory needs no clearing after reset, since only
// rows written in the current set are read.
`default_nettype none

module vector_mean_variance_top (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   sample_valid,
    output logic                  sample_stall,
    input  wire vmv_pkg::sample_t component_0,
    input  wire vmv_pkg::sample_t component_1,
    input  wire vmv_pkg::sample_t component_2,
    input  wire vmv_pkg::sample_t component_3,
    input  wire vmv_pkg::sample_t component_4,
    input  wire vmv_pkg::sample_t component_5,
    input  wire vmv_pkg::sample_t component_6,
    input  wire                   last_vector,
    output logic                  result_valid,
    input  wire                   result_stall,
    output vmv_pkg::dim_t         dim_index,
    output vmv_pkg::sample_t      mean_value,
    output vmv_pkg::var_t         variance_value,
    output logic                  overflowed,
    output logic                  last_result
);
    import vmv_pkg::*;

    vmv_state_t state_reg;
    vmv_state_t state_next;

    logic signed [SUM_W-1:0] sum_reg [DIMENSIONS];
    count_t                  count_reg;
    logic                    drop_reg;
    dim_t                    dim_reg;
    logic                    neg_reg;
    sample_t                 mean_reg;
    count_t                  issue_reg;
    logic                    rd_v_reg;
    logic                    diff_v_reg;
    logic                    sq_v_reg;
    row_t                    row_rd_reg;
    logic signed [SAMPLE_WIDTH:0] diff_reg;
    logic [SQ_W-1:0]         sq_reg;
    wide_t                   acc_reg;
    var_t                    var_reg;

    logic                    out_valid_reg;
    dim_t                    out_dim_reg;
    sample_t                 out_mean_reg;
    var_t                    out_var_reg;
    logic                    out_ovf_reg;
    logic                    out_last_reg;

    row_t                    mem [MAX_VECTORS];
    row_t                    wr_row;

    logic                    in_accept;
    logic                    store_ok;
    logic                    issue;
    logic                    pass_done;
    logic                    out_free;
    logic                    final_dim;
    logic                    div_start;
    wide_t                   div_dividend;
    logic                    div_done;
    wide_t                   div_quot;
    logic [SUM_W-1:0]        sum_mag;
    sample_t                 quot_low;
    sample_t                 sel_sample;
    logic signed [2*SAMPLE_WIDTH+1:0] prod;

    assign in_accept = sample_valid && !sample_stall;
    assign store_ok  = count_reg < CNT_W'(MAX_VECTORS);
    assign issue     = (state_reg == ST_PASS) && (issue_reg < count_reg);
    assign pass_done = (state_reg == ST_PASS) && (issue_reg == count_reg)
                       && !rd_v_reg && !diff_v_reg && !sq_v_reg;
    assign out_free  = !out_valid_reg || !result_stall;
    assign final_dim = dim_reg == DIM_W'(DIMENSIONS - 1);
    assign sum_mag   = sum_reg[dim_reg][SUM_W-1] ? -sum_reg[dim_reg] : sum_reg[dim_reg];
    assign quot_low  = div_quot[SAMPLE_WIDTH-1:0];
    assign sel_sample = row_rd_reg[dim_reg];
    assign prod      = diff_reg * diff_reg;

    assign wr_row = {component_6, component_5, component_4, component_3,
                     component_2, component_1, component_0};

    vmv_div u_vmv_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = ACC_W'(sum_mag);
        sample_stall = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                sample_stall = 1'b0;
                if (in_accept && last_vector)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (pass_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = acc_reg;
                    state_next   = ST_VDIV;
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = final_dim ? ST_LOAD : ST_START;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                sum_reg[d] <= '0;
            end
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            dim_reg       <= '0;
            issue_reg     <= '0;
            rd_v_reg      <= 1'b0;
            diff_v_reg    <= 1'b0;
            sq_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= issue;
            diff_v_reg <= rd_v_reg;
            sq_v_reg   <= diff_v_reg;
            if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (state_reg == ST_MEAN && div_done)
            begin
                issue_reg <= '0;
            end
            if (in_accept)
            begin
                if (store_ok)
                begin
                    for (int d = 0; d < DIMENSIONS; d++)
                    begin
                        sum_reg[d] <= sum_reg[d] + SUM_W'(wr_row[d]);
                    end
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (final_dim)
                begin
                    for (int d = 0; d < DIMENSIONS; d++)
                    begin
                        sum_reg[d] <= '0;
                    end
                    count_reg <= '0;
                    drop_reg  <= 1'b0;
                    dim_reg   <= '0;
                end
                else
                begin
                    dim_reg <= dim_reg + 1'b1;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && store_ok)
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_row;
        end
        row_rd_reg <= mem[issue_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_START)
        begin
            neg_reg <= sum_reg[dim_reg][SUM_W-1];
        end
        if (state_reg == ST_MEAN && div_done)
        begin
            mean_reg <= neg_reg ? -quot_low : quot_low;
            acc_reg  <= '0;
        end
        diff_reg <= (SAMPLE_WIDTH+1)'(mean_reg) - (SAMPLE_WIDTH+1)'(sel_sample);
        sq_reg   <= prod[SQ_W-1:0];
        if (sq_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        if (state_reg == ST_VDIV && div_done)
        begin
            var_reg <= div_quot[VAR_W-1:0];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_dim_reg  <= dim_reg;
            out_mean_reg <= mean_reg;
            out_var_reg  <= var_reg;
            out_ovf_reg  <= drop_reg;
            out_last_reg <= final_dim;
        end
    end

    assign result_valid   = out_valid_reg;
    assign dim_index      = out_dim_reg;
    assign mean_value     = out_mean_reg;
    assign variance_value = out_var_reg;
    assign overflowed     = out_ovf_reg;
    assign last_result    = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/vmv_port_checker.sv
// Port-level assertion checker for the mean and variance block, with its bind.
`default_nettype none

`include "vector_mean_variance_top_assert.svh"

module vmv_port_checker (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   sample_valid,
    input  wire                   sample_stall,
    input  wire                   last_vector,
    input  wire                   result_valid,
    input  wire                   result_stall,
    input  wire vmv_pkg::dim_t    dim_index,
    input  wire vmv_pkg::sample_t mean_value,
    input  wire vmv_pkg::var_t    variance_value,
    input  wire                   last_result
);
    import vmv_pkg::*;

    logic                                  held_result;
    logic [DIM_W+SAMPLE_WIDTH+VAR_W-1:0]   payload;
    logic                                  final_dim;
    logic                                  closing_accept;

    assign held_result    = result_valid && result_stall;
    assign payload        = {dim_index, mean_value, variance_value};
    assign final_dim      = dim_index == DIM_W'(DIMENSIONS - 1);
    assign closing_accept = sample_valid && !sample_stall && last_vector;

    `VMV_ASSERT_NEXT(a_hold, held_result, result_valid && $stable(payload), "stalled result changed")
    `VMV_ASSERT_NOW(a_last_marker, result_valid, last_result == final_dim, "misplaced last marker")
    `VMV_ASSERT_NOW(a_dim_range, result_valid, dim_index < DIM_W'(DIMENSIONS), "index out of range")
    `VMV_ASSERT_NEXT(a_close_stalls, closing_accept, sample_stall, "no stall after closing request")

endmodule

bind vector_mean_variance_top vmv_port_checker u_vmv_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .last_vector    (last_vector),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .dim_index      (dim_index),
    .mean_value     (mean_value),
    .variance_value (variance_value),
    .last_result    (last_result)
);

`default_nettype wire
